FILE: rtl/core/three_level_feedback_scheduler_top_assert.svh
// Assertion macros used by the scheduler RTL.
// Each expects signals named clk and rst_n in the including module.
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_TOP_ASSERT_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TLFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tlfs_pkg.sv
// Shared constants, types and helpers of the three-level feedback scheduler.
// No dependencies.
package tlfs_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int TIME_BITS = 16;
  localparam int LEVELS    = 3;

  localparam int JIDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int QIDX_W = $clog2(LEVELS);
  localparam int QA_W   = $clog2(LEVELS * MAX_JOBS);

  // Field widths of the channels
  localparam int OP_W   = 1;
  localparam int ID_W   = 4;
  localparam int SVC_W  = 8;
  localparam int QNT_W  = 8;
  localparam int ST_W   = 2;
  localparam int LVL_W  = 2;
  localparam int TURN_W = 16;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
  localparam logic [OP_W-1:0] OP_ADMIT = 1'b1;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_JOB = 2'd2;

  localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

  localparam logic [1:0] REG_QUANTUM_ONE   = 2'd0;
  localparam logic [1:0] REG_QUANTUM_TWO   = 2'd1;
  localparam logic [1:0] REG_QUANTUM_THREE = 2'd2;

  localparam logic [QNT_W-1:0] QUANTUM_ONE_RST   = 8'd4;
  localparam logic [QNT_W-1:0] QUANTUM_TWO_RST   = 8'd8;
  localparam logic [QNT_W-1:0] QUANTUM_THREE_RST = 8'd16;

  typedef struct packed {
    logic [QNT_W-1:0] q1;
    logic [QNT_W-1:0] q2;
    logic [QNT_W-1:0] q3;
  } cfg_t;

  typedef struct packed {
    logic [SVC_W-1:0]     rem;
    logic [QNT_W-1:0]     ql;
    logic [TIME_BITS-1:0] admit;
    logic [SVC_W-1:0]     svc;
  } jt_entry_t;

  localparam int JT_W = $bits(jt_entry_t);

  typedef struct packed {
    logic              push;
    logic [QIDX_W-1:0] push_q;
    logic              pop;
    logic [QIDX_W-1:0] pop_q;
  } q_req_t;

  typedef struct packed {
    logic [LEVELS-1:0] nonempty;
    logic [QA_W-1:0]   push_addr;
    logic [QA_W-1:0]   pop_addr;
  } q_stat_t;

  typedef struct packed {
    logic              we;
    logic [QA_W-1:0]   addr;
    logic [JIDX_W-1:0] data;
  } qm_wr_t;

  typedef struct packed {
    logic              we;
    logic [JIDX_W-1:0] addr;
    jt_entry_t         data;
  } jt_wr_t;

  function automatic logic [QNT_W-1:0] quantum_of(cfg_t c, logic [LVL_W-1:0] lvl);
    logic [QNT_W-1:0] q;
    if (lvl == LVL_ONE) q = c.q1;
    else if (lvl == LVL_TWO) q = c.q2;
    else q = c.q3;
    return q;
  endfunction

endpackage

FILE: rtl/core/tlfs_if.sv
// Valid/ready channel interfaces: job items in, scheduler results out.
// Depends on tlfs_pkg.
interface tlfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlfs_pkg::OP_W-1:0]   opcode;
  logic [tlfs_pkg::ID_W-1:0]   job_id;
  logic [tlfs_pkg::SVC_W-1:0]  service_time;

  modport source (output valid, opcode, job_id, service_time, input ready);
  modport sink   (input valid, opcode, job_id, service_time, output ready);
endinterface

interface tlfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlfs_pkg::ST_W-1:0]   status;
  logic [tlfs_pkg::ID_W-1:0]   ran_job;
  logic [tlfs_pkg::LVL_W-1:0]  ran_level;
  logic                        job_done;
  logic [tlfs_pkg::TURN_W-1:0] turnaround;
  logic [tlfs_pkg::SVC_W-1:0]  done_service;

  modport source (output valid, status, ran_job, ran_level, job_done, turnaround,
                  done_service, input ready);
  modport sink   (input valid, status, ran_job, ran_level, job_done, turnaround,
                  done_service, output ready);
endinterface

FILE: rtl/core/tlfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tlfs_qptr.sv
// Head and count registers of the three level FIFOs, plus slot addressing
// into the shared queue memory. Depends on tlfs_pkg.
module tlfs_qptr (
  input  logic              clk,
  input  logic              rst_n,
  input  tlfs_pkg::q_req_t  req,
  output tlfs_pkg::q_stat_t stat
);

  localparam int SUM_W = tlfs_pkg::JIDX_W + 1;

  logic [tlfs_pkg::JIDX_W-1:0] head_r   [tlfs_pkg::LEVELS];
  logic [tlfs_pkg::JIDX_W-1:0] head_nxt [tlfs_pkg::LEVELS];
  logic [tlfs_pkg::CNT_W-1:0]  cnt_r    [tlfs_pkg::LEVELS];
  logic [tlfs_pkg::CNT_W-1:0]  cnt_nxt  [tlfs_pkg::LEVELS];

  logic [SUM_W-1:0]            tail_sum;
  logic [tlfs_pkg::JIDX_W-1:0] tail_slot;
  logic                        push_ok;

  // tail = (head + count) mod MAX_JOBS; the sum stays below twice the depth
  always_comb begin
    tail_sum = SUM_W'(head_r[req.push_q]) + SUM_W'(cnt_r[req.push_q]);
    if (tail_sum >= SUM_W'(tlfs_pkg::MAX_JOBS)) begin
      tail_slot = tlfs_pkg::JIDX_W'(tail_sum - SUM_W'(tlfs_pkg::MAX_JOBS));
    end else begin
      tail_slot = tlfs_pkg::JIDX_W'(tail_sum);
    end
    push_ok = req.push && (cnt_r[req.push_q] != tlfs_pkg::CNT_W'(tlfs_pkg::MAX_JOBS));

    stat.push_addr = tlfs_pkg::QA_W'(req.push_q) * tlfs_pkg::QA_W'(tlfs_pkg::MAX_JOBS)
                   + tlfs_pkg::QA_W'(tail_slot);
    stat.pop_addr  = tlfs_pkg::QA_W'(req.pop_q) * tlfs_pkg::QA_W'(tlfs_pkg::MAX_JOBS)
                   + tlfs_pkg::QA_W'(head_r[req.pop_q]);

    for (int i = 0; i < tlfs_pkg::LEVELS; i++) begin
      stat.nonempty[i] = (cnt_r[i] != '0);
      head_nxt[i] = head_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (push_ok && (req.push_q == tlfs_pkg::QIDX_W'(i))) begin
        cnt_nxt[i] = cnt_nxt[i] + tlfs_pkg::CNT_W'(1);
      end
      if (req.pop && (req.pop_q == tlfs_pkg::QIDX_W'(i))) begin
        cnt_nxt[i] = cnt_nxt[i] - tlfs_pkg::CNT_W'(1);
        if (head_r[i] == tlfs_pkg::JIDX_W'(tlfs_pkg::MAX_JOBS - 1)) begin
          head_nxt[i] = '0;
        end else begin
          head_nxt[i] = head_r[i] + tlfs_pkg::JIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tlfs_pkg::LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < tlfs_pkg::LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

endmodule

FILE: rtl/core/tlfs_ctrl.sv
// Scheduler sequencer: admit and tick handling, running-job cache, busy bits,
// result register. Depends on tlfs_pkg, tlfs_if and the assertion macros.
`include "three_level_feedback_scheduler_top_assert.svh"

module tlfs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  tlfs_in_if.sink                     in_chan,
  tlfs_out_if.source                  out_chan,
  input  tlfs_pkg::cfg_t              cfg,
  output tlfs_pkg::q_req_t            q_req,
  input  tlfs_pkg::q_stat_t           q_stat,
  output tlfs_pkg::qm_wr_t            qm_wr,
  input  logic [tlfs_pkg::JIDX_W-1:0] qm_rdata,
  output tlfs_pkg::jt_wr_t            jt_wr,
  output logic [tlfs_pkg::JIDX_W-1:0] jt_raddr,
  input  tlfs_pkg::jt_entry_t         jt_rdata
);

  typedef enum logic [2:0] {S_IDLE, S_ADMIT, S_NOJOB, S_QRD, S_JRD, S_EXEC} state_t;

  state_t                         state_r, state_nxt;
  logic [tlfs_pkg::TIME_BITS-1:0] time_r, time_nxt;
  logic [tlfs_pkg::MAX_JOBS-1:0]  busy_r, busy_nxt;
  logic                           run_v_r, run_v_nxt;
  logic [tlfs_pkg::JIDX_W-1:0]    run_id_r, run_id_nxt;
  logic [tlfs_pkg::LVL_W-1:0]     run_lvl_r, run_lvl_nxt;

  // cached table entry of the running job
  logic [tlfs_pkg::SVC_W-1:0]     rem_r, rem_nxt;
  logic [tlfs_pkg::QNT_W-1:0]     ql_r, ql_nxt;
  logic [tlfs_pkg::TIME_BITS-1:0] admit_r, admit_nxt;
  logic [tlfs_pkg::SVC_W-1:0]     svc_r, svc_nxt;

  logic [tlfs_pkg::ID_W-1:0]      adm_id_r, adm_id_nxt;
  logic [tlfs_pkg::SVC_W-1:0]     adm_svc_r, adm_svc_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [tlfs_pkg::ST_W-1:0]      o_status_r, o_status_nxt;
  logic [tlfs_pkg::ID_W-1:0]      o_job_r, o_job_nxt;
  logic [tlfs_pkg::LVL_W-1:0]     o_level_r, o_level_nxt;
  logic                           o_done_r, o_done_nxt;
  logic [tlfs_pkg::TURN_W-1:0]    o_turn_r, o_turn_nxt;
  logic [tlfs_pkg::SVC_W-1:0]     o_dsvc_r, o_dsvc_nxt;

  logic                           out_free;
  logic                           higher;
  logic                           preempt;
  logic                           any_ne;
  logic [tlfs_pkg::QIDX_W-1:0]    sel_q;
  logic [tlfs_pkg::LVL_W-1:0]     next_lvl;
  logic [tlfs_pkg::TIME_BITS-1:0] time_inc;
  logic [tlfs_pkg::TIME_BITS-1:0] tdiff;
  logic [tlfs_pkg::JIDX_W-1:0]    adm_idx;
  logic                           reject;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = o_status_r;
  assign out_chan.ran_job      = o_job_r;
  assign out_chan.ran_level    = o_level_r;
  assign out_chan.job_done     = o_done_r;
  assign out_chan.turnaround   = o_turn_r;
  assign out_chan.done_service = o_dsvc_r;

  // popped id from the queue memory addresses the job table directly
  assign jt_raddr = qm_rdata;

  always_comb begin
    state_nxt   = state_r;
    time_nxt    = time_r;
    busy_nxt    = busy_r;
    run_v_nxt   = run_v_r;
    run_id_nxt  = run_id_r;
    run_lvl_nxt = run_lvl_r;
    rem_nxt     = rem_r;
    ql_nxt      = ql_r;
    admit_nxt   = admit_r;
    svc_nxt     = svc_r;
    adm_id_nxt  = adm_id_r;
    adm_svc_nxt = adm_svc_r;

    out_free      = !out_valid_r || out_chan.ready;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    o_status_nxt  = o_status_r;
    o_job_nxt     = o_job_r;
    o_level_nxt   = o_level_r;
    o_done_nxt    = o_done_r;
    o_turn_nxt    = o_turn_r;
    o_dsvc_nxt    = o_dsvc_r;

    q_req         = '0;
    qm_wr.we      = 1'b0;
    qm_wr.addr    = q_stat.push_addr;
    qm_wr.data    = run_id_r;
    jt_wr.we      = 1'b0;
    jt_wr.addr    = run_id_r;
    jt_wr.data.rem   = rem_r;
    jt_wr.data.ql    = ql_r;
    jt_wr.data.admit = admit_r;
    jt_wr.data.svc   = svc_r;

    time_inc = time_r + tlfs_pkg::TIME_BITS'(1);
    tdiff    = time_inc - admit_r;
    adm_idx  = tlfs_pkg::JIDX_W'(adm_id_r);
    reject   = (32'(adm_id_r) >= tlfs_pkg::MAX_JOBS) || busy_r[adm_idx];

    any_ne = |q_stat.nonempty;
    if (q_stat.nonempty[0]) sel_q = tlfs_pkg::QIDX_W'(0);
    else if (q_stat.nonempty[1]) sel_q = tlfs_pkg::QIDX_W'(1);
    else sel_q = tlfs_pkg::QIDX_W'(2);

    higher  = q_stat.nonempty[0] ||
              ((run_lvl_r == tlfs_pkg::LVL_THREE) && q_stat.nonempty[1]);
    preempt = run_v_r && (run_lvl_r != tlfs_pkg::LVL_ONE) && higher;

    if (run_lvl_r == tlfs_pkg::LVL_THREE) next_lvl = tlfs_pkg::LVL_THREE;
    else next_lvl = run_lvl_r + tlfs_pkg::LVL_ONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          adm_id_nxt  = in_chan.job_id;
          adm_svc_nxt = in_chan.service_time;
          if (in_chan.opcode == tlfs_pkg::OP_ADMIT) begin
            state_nxt = S_ADMIT;
          end else begin
            // preempted job goes back to its own FIFO; level 3 restarts its slice
            if (preempt) begin
              jt_wr.we = 1'b1;
              if (run_lvl_r == tlfs_pkg::LVL_THREE) jt_wr.data.ql = cfg.q3;
              q_req.push   = 1'b1;
              q_req.push_q = tlfs_pkg::QIDX_W'(run_lvl_r - tlfs_pkg::LVL_ONE);
              qm_wr.we     = 1'b1;
            end
            if (!run_v_r || preempt) begin
              if (any_ne) begin
                q_req.pop   = 1'b1;
                q_req.pop_q = sel_q;
                run_lvl_nxt = tlfs_pkg::LVL_W'(sel_q) + tlfs_pkg::LVL_ONE;
                run_v_nxt   = 1'b0;
                state_nxt   = S_QRD;
              end else begin
                state_nxt = S_NOJOB;
              end
            end else begin
              state_nxt = S_EXEC;
            end
          end
        end
      end

      S_ADMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = reject ? tlfs_pkg::ST_REJECT : tlfs_pkg::ST_OK;
          o_job_nxt     = '0;
          o_level_nxt   = '0;
          o_done_nxt    = 1'b0;
          o_turn_nxt    = '0;
          o_dsvc_nxt    = '0;
          if (!reject) begin
            busy_nxt[adm_idx] = 1'b1;
            jt_wr.we         = 1'b1;
            jt_wr.addr       = adm_idx;
            jt_wr.data.rem   = adm_svc_r;
            jt_wr.data.ql    = cfg.q1;
            jt_wr.data.admit = time_r;
            jt_wr.data.svc   = adm_svc_r;
            q_req.push       = 1'b1;
            q_req.push_q     = tlfs_pkg::QIDX_W'(0);
            qm_wr.we         = 1'b1;
            qm_wr.data       = adm_idx;
          end
          state_nxt = S_IDLE;
        end
      end

      S_NOJOB: begin
        if (out_free) begin
          time_nxt      = time_inc;
          out_valid_nxt = 1'b1;
          o_status_nxt  = tlfs_pkg::ST_NO_JOB;
          o_job_nxt     = '0;
          o_level_nxt   = '0;
          o_done_nxt    = 1'b0;
          o_turn_nxt    = '0;
          o_dsvc_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end

      S_QRD: begin
        run_id_nxt = qm_rdata;
        state_nxt  = S_JRD;
      end

      S_JRD: begin
        rem_nxt   = jt_rdata.rem;
        ql_nxt    = jt_rdata.ql;
        admit_nxt = jt_rdata.admit;
        svc_nxt   = jt_rdata.svc;
        run_v_nxt = 1'b1;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        if (out_free) begin
          time_nxt      = time_inc;
          out_valid_nxt = 1'b1;
          o_status_nxt  = tlfs_pkg::ST_OK;
          o_job_nxt     = tlfs_pkg::ID_W'(run_id_r);
          o_level_nxt   = run_lvl_r;
          o_done_nxt    = 1'b0;
          o_turn_nxt    = '0;
          o_dsvc_nxt    = '0;
          if (rem_r <= tlfs_pkg::SVC_W'(1)) begin
            rem_nxt          = '0;
            busy_nxt[run_id_r] = 1'b0;
            run_v_nxt        = 1'b0;
            o_done_nxt       = 1'b1;
            o_turn_nxt       = tlfs_pkg::TURN_W'(tdiff);
            o_dsvc_nxt       = svc_r;
          end else begin
            rem_nxt = rem_r - tlfs_pkg::SVC_W'(1);
            if (ql_r <= tlfs_pkg::QNT_W'(1)) begin
              // slice used up: write back and demote (level 3 requeues at level 3)
              jt_wr.we       = 1'b1;
              jt_wr.data.rem = rem_r - tlfs_pkg::SVC_W'(1);
              jt_wr.data.ql  = tlfs_pkg::quantum_of(cfg, next_lvl);
              q_req.push     = 1'b1;
              q_req.push_q   = tlfs_pkg::QIDX_W'(next_lvl - tlfs_pkg::LVL_ONE);
              qm_wr.we       = 1'b1;
              run_v_nxt      = 1'b0;
            end else begin
              ql_nxt = ql_r - tlfs_pkg::QNT_W'(1);
            end
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      busy_r      <= '0;
      run_v_r     <= 1'b0;
      run_lvl_r   <= tlfs_pkg::LVL_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      busy_r      <= busy_nxt;
      run_v_r     <= run_v_nxt;
      run_lvl_r   <= run_lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    run_id_r   <= run_id_nxt;
    rem_r      <= rem_nxt;
    ql_r       <= ql_nxt;
    admit_r    <= admit_nxt;
    svc_r      <= svc_nxt;
    adm_id_r   <= adm_id_nxt;
    adm_svc_r  <= adm_svc_nxt;
    o_status_r <= o_status_nxt;
    o_job_r    <= o_job_nxt;
    o_level_r  <= o_level_nxt;
    o_done_r   <= o_done_nxt;
    o_turn_r   <= o_turn_nxt;
    o_dsvc_r   <= o_dsvc_nxt;
  end

  `TLFS_ASSERT_NOW(a_run_busy, run_v_r, busy_r[run_id_r], "running job is not busy")
  `TLFS_ASSERT_NOW(a_pop_nonempty, q_req.pop, q_stat.nonempty[q_req.pop_q], "pop from empty FIFO")
  `TLFS_ASSERT_NOW(a_push_pop_split, q_req.push && q_req.pop, q_req.push_q != q_req.pop_q, "push and pop hit one FIFO")
  `TLFS_ASSERT_NEXT(a_load_exec, state_r == S_JRD, run_v_r && (state_r == S_EXEC), "job load did not reach execute")

endmodule

FILE: rtl/core/three_level_feedback_scheduler_top.sv
// Three-level feedback queue scheduler: a one-to-one item/result block.
// Input channel in_chan carries opcode (tick or admit), job_id, service_time;
// output channel out_chan returns one result per item: status, ran_job,
// ran_level, job_done, turnaround and done_service. The quantum of each
// level is set over the APB-style cfg_ port (0x0, 0x4, 0x8), which the user
// must do only while idle; the block does not enforce it. An admit goes to
// S_ADMIT, a tick whose job keeps running to S_EXEC, one that starts a new
// job to S_QRD and S_JRD: the pop reads the queue memory, then the popped id
// reads the job table RAM, each registered. One item is in work at a time.
// Reset: all FIFOs empty, no job busy or running, time zero, quanta 4/8/16;
// the memories need no clearing pass and the block is ready at once.
// Receiver stall: the result register holds its transfer; the next item is
// still accepted and worked on, and waits only when its own result is due.
// Depends on tlfs_pkg, tlfs_if, tlfs_ram, tlfs_qptr and tlfs_ctrl.
module three_level_feedback_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  tlfs_in_if.sink                     in_chan,
  tlfs_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tlfs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tlfs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tlfs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  tlfs_pkg::cfg_t              cfg_r, cfg_nxt;
  tlfs_pkg::q_req_t            q_req;
  tlfs_pkg::q_stat_t           q_stat;
  tlfs_pkg::qm_wr_t            qm_wr;
  tlfs_pkg::jt_wr_t            jt_wr;
  logic [tlfs_pkg::JIDX_W-1:0] qm_rdata;
  logic [tlfs_pkg::JIDX_W-1:0] jt_raddr;
  tlfs_pkg::jt_entry_t         jt_rdata;
  logic [1:0]                  reg_idx;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[tlfs_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt    = cfg_r;
    cfg_prdata = '0;
    unique case (reg_idx)
      tlfs_pkg::REG_QUANTUM_ONE: begin
        cfg_prdata = tlfs_pkg::CFG_DW'(cfg_r.q1);
        if (cfg_wr) cfg_nxt.q1 = cfg_pwdata[tlfs_pkg::QNT_W-1:0];
      end
      tlfs_pkg::REG_QUANTUM_TWO: begin
        cfg_prdata = tlfs_pkg::CFG_DW'(cfg_r.q2);
        if (cfg_wr) cfg_nxt.q2 = cfg_pwdata[tlfs_pkg::QNT_W-1:0];
      end
      tlfs_pkg::REG_QUANTUM_THREE: begin
        cfg_prdata = tlfs_pkg::CFG_DW'(cfg_r.q3);
        if (cfg_wr) cfg_nxt.q3 = cfg_pwdata[tlfs_pkg::QNT_W-1:0];
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.q1 <= tlfs_pkg::QUANTUM_ONE_RST;
      cfg_r.q2 <= tlfs_pkg::QUANTUM_TWO_RST;
      cfg_r.q3 <= tlfs_pkg::QUANTUM_THREE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // all three level FIFOs share one memory, one row of MAX_JOBS per level
  tlfs_ram #(
    .WIDTH (tlfs_pkg::JIDX_W),
    .DEPTH (tlfs_pkg::LEVELS * tlfs_pkg::MAX_JOBS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (qm_wr.we),
    .waddr (qm_wr.addr),
    .wdata (qm_wr.data),
    .raddr (q_stat.pop_addr),
    .rdata (qm_rdata)
  );

  tlfs_ram #(
    .WIDTH (tlfs_pkg::JT_W),
    .DEPTH (tlfs_pkg::MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (jt_wr.we),
    .waddr (jt_wr.addr),
    .wdata (jt_wr.data),
    .raddr (jt_raddr),
    .rdata (jt_rdata)
  );

  tlfs_qptr u_qptr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (q_req),
    .stat  (q_stat)
  );

  tlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg      (cfg_r),
    .q_req    (q_req),
    .q_stat   (q_stat),
    .qm_wr    (qm_wr),
    .qm_rdata (qm_rdata),
    .jt_wr    (jt_wr),
    .jt_raddr (jt_raddr),
    .jt_rdata (jt_rdata)
  );

endmodule
